// ===== hdl/ksr_pkg.sv =====
// Package for the knock sequence recorder: shared types, codes and reset values.
package ksr_pkg;

    localparam int STAMP_W  = 24;
    localparam int INDEX_W  = 8;
    localparam int SAMPLE_W = 10;
    localparam int WAIT_W   = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    // Result kinds
    localparam logic KIND_KNOCK  = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Input commands
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TICKS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KNOCKS    = 3'd5;

    // Reset values of the configuration registers
    localparam logic [9:0]  RST_TRIGGER_LEVEL = 10'd100;
    localparam logic [15:0] RST_FIRST_TIMEOUT = 16'd5000;
    localparam logic [15:0] RST_GAP_TIMEOUT   = 16'd1000;
    localparam logic [7:0]  RST_DEAD_TICKS    = 8'd30;
    localparam logic [7:0]  RST_MAX_KNOCKS    = 8'd16;

    // Result queue depth: room for two results from each of two beats
    localparam int QUEUE_DEPTH = 4;
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                listen_mode;
        logic [SAMPLE_W-1:0] trigger_level;
        logic [15:0]         first_timeout;
        logic [15:0]         gap_timeout;
        logic [7:0]          dead_ticks;
        logic [INDEX_W-1:0]  max_knocks;
    } t_cfg;

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] knock_index;
        logic [STAMP_W-1:0] stamp;
        logic [INDEX_W-1:0] knock_total;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic t_result make_result(input logic kind,
                                            input logic [INDEX_W-1:0] idx,
                                            input logic [STAMP_W-1:0] stamp,
                                            input logic [INDEX_W-1:0] total,
                                            input logic last);
        t_result r;
        r.kind        = kind;
        r.knock_index = idx;
        r.stamp       = stamp;
        r.knock_total = total;
        r.last        = last;
        return r;
    endfunction

endpackage

// ===== hdl/knock_sequence_recorder.sv =====
// Top level of the knock sequence recorder: configuration registers and the input channel.
//
// The recorder takes one beat per clock cycle on its input channel: either a start
// command or a one-millisecond tick carrying a 10-bit piezo sample. Each beat is
// handled in the cycle it is accepted, by the sequencer, and the zero, one or two
// results it causes go into a four-entry result queue that drives the output
// channel one result per cycle. Input ready is held low only while the queue
// holds more than two results, so with the output side ready every cycle one
// beat is taken per cycle; a beat that both records the final knock and finishes
// the sequence yields two results, which the queue absorbs. A knock result carries
// its index and the ticks since sequence start (saturating); a finished result
// carries the knock count and the elapsed time at the finish, and the last result
// of each beat is flagged. Configuration registers are written through their own
// channel, which is always ready; writes to indexes beyond the list are ignored,
// and they should only be made while no results are outstanding.
module knock_sequence_recorder import ksr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_command,
    input  logic [SAMPLE_W-1:0]   i_sample,
    // Output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_kind,
    output logic [INDEX_W-1:0]    o_knock_index,
    output logic [STAMP_W-1:0]    o_stamp,
    output logic [INDEX_W-1:0]    o_knock_total,
    output logic                  o_last
);

    t_cfg    r_cfg;
    t_push   push;
    t_result head;
    logic    room;
    logic    in_accept;

    // Configuration registers. The write channel never stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.listen_mode   <= 1'b0;
            r_cfg.trigger_level <= RST_TRIGGER_LEVEL;
            r_cfg.first_timeout <= RST_FIRST_TIMEOUT;
            r_cfg.gap_timeout   <= RST_GAP_TIMEOUT;
            r_cfg.dead_ticks    <= RST_DEAD_TICKS;
            r_cfg.max_knocks    <= RST_MAX_KNOCKS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LISTEN_MODE:   r_cfg.listen_mode   <= i_cfg_data[0];
                CFG_TRIGGER_LEVEL: r_cfg.trigger_level <= i_cfg_data[SAMPLE_W-1:0];
                CFG_FIRST_TIMEOUT: r_cfg.first_timeout <= i_cfg_data[15:0];
                CFG_GAP_TIMEOUT:   r_cfg.gap_timeout   <= i_cfg_data[15:0];
                CFG_DEAD_TICKS:    r_cfg.dead_ticks    <= i_cfg_data[7:0];
                CFG_MAX_KNOCKS:    r_cfg.max_knocks    <= i_cfg_data[INDEX_W-1:0];
                default: begin
                    // Unused index: the write is dropped.
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // A beat is taken whenever the queue can hold everything it might produce.
    assign o_in_ready = room;
    assign in_accept  = i_in_valid && room;

    ksr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_command (i_command),
        .i_sample  (i_sample),
        .i_cfg     (r_cfg),
        .o_push    (push)
    );

    ksr_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop_ready (i_out_ready),
        .o_valid     (o_out_valid),
        .o_head      (head),
        .o_room      (room)
    );

    assign o_kind        = head.kind;
    assign o_knock_index = head.knock_index;
    assign o_stamp       = head.stamp;
    assign o_knock_total = head.knock_total;
    assign o_last        = head.last;

endmodule

// ===== hdl/ksr_ctrl.sv =====
// Recording sequencer: phase, elapsed time, wait counter and knock count.
module ksr_ctrl import ksr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_command,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_cfg                i_cfg,
    output t_push               o_push
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LISTEN,
        PH_RECORD,
        PH_DEAD
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [STAMP_W-1:0]  r_elapsed, n_elapsed;
    logic [WAIT_W-1:0]   r_wait, n_wait;
    logic [INDEX_W-1:0]  r_done, n_done;

    logic [STAMP_W-1:0]  elapsed_inc;
    logic [WAIT_W-1:0]   wait_inc;
    logic [INDEX_W-1:0]  done_inc;
    logic                hit;
    t_phase              after_phase;
    logic [WAIT_W-1:0]   after_wait;

    always_comb begin
        elapsed_inc = (r_elapsed == STAMP_MAX) ? r_elapsed : r_elapsed + 1'b1;
        wait_inc    = r_wait + 1'b1;
        done_inc    = r_done + 1'b1;
        hit         = (i_sample >= i_cfg.trigger_level);
        // After a knock: straight back to waiting when there is no dead time.
        after_phase = (i_cfg.dead_ticks == '0) ? PH_RECORD : PH_DEAD;
        after_wait  = {{(WAIT_W-8){1'b0}}, i_cfg.dead_ticks};
    end

    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_wait    = r_wait;
        n_done    = r_done;
        o_push.count  = 2'd0;
        o_push.first  = make_result(KIND_FINISH, '0, '0, '0, 1'b1);
        o_push.second = make_result(KIND_FINISH, '0, '0, '0, 1'b1);

        if (i_accept) begin
            if (i_command == CMD_START) begin
                n_elapsed = '0;
                n_wait    = '0;
                n_done    = '0;
                if (i_cfg.listen_mode) begin
                    n_phase = PH_LISTEN;
                end else if (i_cfg.max_knocks == '0) begin
                    n_phase = PH_IDLE;
                    o_push.count = 2'd1;
                end else begin
                    n_phase = PH_RECORD;
                end
            end else begin
                case (r_phase)
                    PH_LISTEN: begin
                        n_wait = wait_inc;
                        if (wait_inc > {1'b0, i_cfg.first_timeout}) begin
                            n_phase = PH_IDLE;
                            o_push.count = 2'd1;
                        end else if (hit) begin
                            n_elapsed = '0;
                            if (i_cfg.max_knocks == '0) begin
                                n_phase = PH_IDLE;
                                o_push.count = 2'd1;
                            end else begin
                                n_done = 8'd1;
                                o_push.first = make_result(KIND_KNOCK, '0, '0, '0, 1'b1);
                                o_push.count = 2'd1;
                                if (i_cfg.max_knocks == 8'd1) begin
                                    n_phase = PH_IDLE;
                                    o_push.first.last = 1'b0;
                                    o_push.second = make_result(KIND_FINISH, '0, '0,
                                                                8'd1, 1'b1);
                                    o_push.count = 2'd2;
                                end else begin
                                    n_phase = after_phase;
                                    n_wait  = after_wait;
                                end
                            end
                        end
                    end
                    PH_DEAD: begin
                        n_elapsed = elapsed_inc;
                        if (r_wait <= {{(WAIT_W-1){1'b0}}, 1'b1}) begin
                            n_wait  = '0;
                            n_phase = PH_RECORD;
                        end else begin
                            n_wait = r_wait - 1'b1;
                        end
                    end
                    PH_RECORD: begin
                        n_elapsed = elapsed_inc;
                        n_wait    = wait_inc;
                        if (wait_inc > {1'b0, i_cfg.gap_timeout}) begin
                            n_phase = PH_IDLE;
                            o_push.first = make_result(KIND_FINISH, '0, elapsed_inc,
                                                       r_done, 1'b1);
                            o_push.count = 2'd1;
                        end else if (hit) begin
                            n_done = done_inc;
                            o_push.first = make_result(KIND_KNOCK, r_done, elapsed_inc,
                                                       '0, 1'b1);
                            o_push.count = 2'd1;
                            if (done_inc >= i_cfg.max_knocks) begin
                                n_phase = PH_IDLE;
                                o_push.first.last = 1'b0;
                                o_push.second = make_result(KIND_FINISH, '0, elapsed_inc,
                                                            done_inc, 1'b1);
                                o_push.count = 2'd2;
                            end else begin
                                n_phase = after_phase;
                                n_wait  = after_wait;
                            end
                        end
                    end
                    default: begin
                        // Ticks while idle are dropped.
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= '0;
            r_wait    <= '0;
            r_done    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_wait    <= n_wait;
            r_done    <= n_done;
        end
    end

endmodule

// ===== hdl/ksr_outq.sv =====
// Result queue: takes up to two results per cycle and shifts them out one at a time.
module ksr_outq import ksr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop_ready,
    output logic    o_valid,
    output t_result o_head,
    output logic    o_room
);

    t_result               r_slot [QUEUE_DEPTH];
    t_result               n_slot [QUEUE_DEPTH];
    logic [QCOUNT_W-1:0]   r_count, n_count;
    logic                  pop;
    logic [QCOUNT_W-1:0]   base;

    always_comb begin
        pop     = (r_count != '0) && i_pop_ready;
        base    = r_count - {{(QCOUNT_W-1){1'b0}}, pop};
        n_count = base + {{(QCOUNT_W-2){1'b0}}, i_push.count};
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_slot[i] = pop ? r_slot[(i + 1) % QUEUE_DEPTH] : r_slot[i];
            if ((i_push.count != 2'd0) && (base == QCOUNT_W'(i))) begin
                n_slot[i] = i_push.first;
            end
            if ((i_push.count == 2'd2) && (base + 1'b1 == QCOUNT_W'(i))) begin
                n_slot[i] = i_push.second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[0];
    // Room for the two results that one beat may produce.
    assign o_room  = (r_count <= QCOUNT_W'(QUEUE_DEPTH - 2));

endmodule

// ===== tb/knock_sequence_recorder_tb.sv =====
// Self-checking testbench for the knock sequence recorder, with directed and random knock sequences.
module knock_sequence_recorder_tb;
    import ksr_pkg::*;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_LISTEN,
        SEQ_RECORD,
        SEQ_DEAD
    } t_seq_state;

    typedef struct packed {
        logic                command;
        logic [SAMPLE_W-1:0] sample;
    } t_tick_beat;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_command   = 1'b0;
    logic [SAMPLE_W-1:0]   i_sample    = '0;
    logic                  i_out_ready = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_kind;
    logic [INDEX_W-1:0]    o_knock_index;
    logic [STAMP_W-1:0]    o_stamp;
    logic [INDEX_W-1:0]    o_knock_total;
    logic                  o_last;

    knock_sequence_recorder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_knock_index (o_knock_index),
        .o_stamp       (o_stamp),
        .o_knock_total (o_knock_total),
        .o_last        (o_last)
    );

    // Beats and register writes waiting to be driven, and the results still owed by the block.
    t_tick_beat pending_beats[$];
    t_reg_write pending_writes[$];
    t_result    owed_results[$];

    int beats_queued     = 0;
    int beats_taken      = 0;
    int writes_queued    = 0;
    int writes_taken     = 0;
    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int holdoff_requests = 0;
    int holdoff_served   = 0;
    int holdoff_left     = 0;
    int mismatch_count   = 0;

    // Set at each rising edge when a beat crossed the channel, read by the drivers at the falling edge.
    bit in_beat  = 1'b0;
    bit cfg_beat = 1'b0;

    // Our own copy of the recorder: its settings and its sequence state.
    t_cfg               shadow_cfg;
    t_seq_state         seq_state   = SEQ_IDLE;
    logic [STAMP_W-1:0] seq_elapsed = '0;
    logic [WAIT_W-1:0]  seq_wait    = '0;
    logic [INDEX_W-1:0] seq_knocks  = '0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_result knock_result(input logic [INDEX_W-1:0] idx,
                                             input logic [STAMP_W-1:0] at);
        t_result r;
        r             = '0;
        r.kind        = KIND_KNOCK;
        r.knock_index = idx;
        r.stamp       = at;
        return r;
    endfunction

    function automatic t_result finish_result(input logic [STAMP_W-1:0] at,
                                              input logic [INDEX_W-1:0] total);
        t_result r;
        r             = '0;
        r.kind        = KIND_FINISH;
        r.stamp       = at;
        r.knock_total = total;
        return r;
    endfunction

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_LISTEN_MODE: begin
                shadow_cfg.listen_mode = data[0];
            end
            CFG_TRIGGER_LEVEL: begin
                shadow_cfg.trigger_level = data[SAMPLE_W-1:0];
            end
            CFG_FIRST_TIMEOUT: begin
                shadow_cfg.first_timeout = data;
            end
            CFG_GAP_TIMEOUT: begin
                shadow_cfg.gap_timeout = data;
            end
            CFG_DEAD_TICKS: begin
                shadow_cfg.dead_ticks = data[7:0];
            end
            CFG_MAX_KNOCKS: begin
                shadow_cfg.max_knocks = data[INDEX_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    // After a knock that does not end the sequence: start the dead time, or go straight back to
    // waiting when there is none.
    task automatic start_dead_time();
        if (shadow_cfg.dead_ticks == 0) begin
            seq_state = SEQ_RECORD;
            seq_wait  = '0;
        end else begin
            seq_state = SEQ_DEAD;
            seq_wait  = WAIT_W'(shadow_cfg.dead_ticks);
        end
    endtask

    // Advances the copy of the recorder by one accepted beat and queues the results it owes.
    task automatic record_beat(input t_tick_beat b);
        t_result found[2];
        int      n;
        logic    hit;
        n   = 0;
        hit = (b.sample >= shadow_cfg.trigger_level);
        if (b.command == CMD_START) begin
            // A start abandons whatever was in progress; its sample plays no part.
            seq_elapsed = '0;
            seq_wait    = '0;
            seq_knocks  = '0;
            if (shadow_cfg.listen_mode) begin
                seq_state = SEQ_LISTEN;
            end else if (shadow_cfg.max_knocks == 0) begin
                seq_state = SEQ_IDLE;
                found[n]  = finish_result('0, '0);
                n++;
            end else begin
                seq_state = SEQ_RECORD;
            end
        end else begin
            case (seq_state)
                SEQ_LISTEN: begin
                    // The tick counts itself before the timeout is judged.
                    seq_wait = seq_wait + 1'b1;
                    if (seq_wait > shadow_cfg.first_timeout) begin
                        seq_state = SEQ_IDLE;
                        found[n]  = finish_result('0, '0);
                        n++;
                    end else if (hit) begin
                        seq_elapsed = '0;
                        if (shadow_cfg.max_knocks == 0) begin
                            seq_state = SEQ_IDLE;
                            found[n]  = finish_result('0, '0);
                            n++;
                        end else begin
                            found[n] = knock_result('0, '0);
                            n++;
                            seq_knocks = INDEX_W'(1);
                            if (seq_knocks >= shadow_cfg.max_knocks) begin
                                seq_state = SEQ_IDLE;
                                found[n]  = finish_result(seq_elapsed, seq_knocks);
                                n++;
                            end else begin
                                start_dead_time();
                            end
                        end
                    end
                end
                SEQ_DEAD: begin
                    if (seq_elapsed != STAMP_MAX) seq_elapsed = seq_elapsed + 1'b1;
                    if (seq_wait != 0) seq_wait = seq_wait - 1'b1;
                    if (seq_wait == 0) seq_state = SEQ_RECORD;
                end
                SEQ_RECORD: begin
                    if (seq_elapsed != STAMP_MAX) seq_elapsed = seq_elapsed + 1'b1;
                    seq_wait = seq_wait + 1'b1;
                    if (seq_wait > shadow_cfg.gap_timeout) begin
                        seq_state = SEQ_IDLE;
                        found[n]  = finish_result(seq_elapsed, seq_knocks);
                        n++;
                    end else if (hit) begin
                        found[n] = knock_result(seq_knocks, seq_elapsed);
                        n++;
                        seq_knocks = seq_knocks + 1'b1;
                        if (seq_knocks >= shadow_cfg.max_knocks) begin
                            // The final knock and the finish come out on the same tick.
                            seq_state = SEQ_IDLE;
                            found[n]  = finish_result(seq_elapsed, seq_knocks);
                            n++;
                        end else begin
                            start_dead_time();
                        end
                    end
                end
                default: begin
                    // A tick while idle is dropped without a result.
                end
            endcase
        end
        if (n > 0) found[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) owed_results.push_back(found[k]);
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Everything is observed at the rising edge: register writes update our settings, input beats
    // drive the prediction, and every output beat is matched against the oldest owed result.
    always @(posedge i_clk) begin
        t_tick_beat seen;
        t_result    want;
        in_beat  = i_rst_n && i_in_valid && o_in_ready;
        cfg_beat = i_rst_n && i_cfg_valid && o_cfg_ready;
        if (cfg_beat) begin
            apply_write(i_cfg_index, i_cfg_data);
            writes_taken++;
        end
        if (in_beat) begin
            seen.command = i_command;
            seen.sample  = i_sample;
            record_beat(seen);
            beats_taken++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_results.size() == 0) begin
                $display("%0t: result with none expected, kind %0d index %0d stamp %0d total %0d",
                         $time, o_kind, o_knock_index, o_stamp, o_knock_total);
                mismatch_count++;
            end else begin
                want = owed_results.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("knock_index", want.knock_index, o_knock_index);
                check_field("stamp", want.stamp, o_stamp);
                check_field("knock_total", want.knock_total, o_knock_total);
                check_field("last", want.last, o_last);
            end
        end
    end

    // Sender side: a beat stays on the channel until it is taken, then the next one may follow
    // straight away or after a random gap.
    always @(negedge i_clk) begin
        t_tick_beat b;
        t_reg_write w;
        if (!i_in_valid || in_beat) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                b = pending_beats.pop_front();
                i_in_valid <= 1'b1;
                i_command  <= b.command;
                i_sample   <= b.sample;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        if (!i_cfg_valid || cfg_beat) begin
            if (pending_writes.size() > 0) begin
                w = pending_writes.pop_front();
                i_cfg_valid <= 1'b1;
                i_cfg_index <= w.index;
                i_cfg_data  <= w.data;
            end else begin
                i_cfg_valid <= 1'b0;
            end
        end
    end

    // Receiver side: random stalls, plus a long hold-off on request so that the result queue
    // fills and the block has to push back on its input.
    always @(negedge i_clk) begin
        if (holdoff_served != holdoff_requests) begin
            holdoff_served = holdoff_requests;
            holdoff_left   = 400;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_beat(input logic command, input int sample);
        t_tick_beat b;
        b.command = command;
        b.sample  = SAMPLE_W'(sample);
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        t_reg_write w;
        w.index = idx;
        w.data  = data;
        pending_writes.push_back(w);
        writes_queued++;
    endtask

    // Writes every register, with junk in the unused upper bits, plus one write to an index past
    // the end of the list, which the block must ignore.
    task automatic load_settings(input int listen, input int trig, input int first_wait,
                                 input int gap, input int dead, input int most);
        logic [CFG_DATA_W-1:0] noisy;
        noisy    = CFG_DATA_W'($urandom);
        noisy[0] = listen[0];
        write_reg(CFG_LISTEN_MODE, noisy);
        noisy                 = CFG_DATA_W'($urandom);
        noisy[SAMPLE_W-1:0]   = trig[SAMPLE_W-1:0];
        write_reg(CFG_TRIGGER_LEVEL, noisy);
        write_reg(CFG_FIRST_TIMEOUT, CFG_DATA_W'(first_wait));
        write_reg(CFG_GAP_TIMEOUT, CFG_DATA_W'(gap));
        noisy      = CFG_DATA_W'($urandom);
        noisy[7:0] = dead[7:0];
        write_reg(CFG_DEAD_TICKS, noisy);
        noisy      = CFG_DATA_W'($urandom);
        noisy[7:0] = most[7:0];
        write_reg(CFG_MAX_KNOCKS, noisy);
        write_reg(CFG_IDX_W'(CFG_MAX_KNOCKS + 1 + $urandom_range(1)), CFG_DATA_W'($urandom));
        while (writes_taken != writes_queued) @(posedge i_clk);
    endtask

    // Waits until every beat has been taken and every owed result has come out, then waits on
    // in case a beat that owes nothing is still being handled.
    task automatic settle();
        while (!(beats_taken == beats_queued && owed_results.size() == 0)) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic int tick_sample(input int trig);
        if (trig == 0 || $urandom_range(3) == 0) return $urandom_range(1023, trig);
        return $urandom_range(trig - 1, 0);
    endfunction

    // Mostly well-formed sequences (a start and a run of ticks, about one in four a knock), with
    // some noise of random starts and ticks in between.
    task automatic queue_random_phase(input int trig, input int count);
        int made;
        int len;
        made = 0;
        while (made < count) begin
            if ($urandom_range(99) < 85) begin
                queue_beat(CMD_START, $urandom_range(1023));
                len = $urandom_range(40, 1);
                for (int k = 0; k < len; k++) queue_beat(CMD_TICK, tick_sample(trig));
                made += len + 1;
            end else begin
                len = $urandom_range(5, 1);
                for (int k = 0; k < len; k++) begin
                    queue_beat(($urandom_range(9) == 0) ? CMD_START : CMD_TICK,
                               $urandom_range(1023));
                end
                made += len;
            end
        end
    endtask

    initial begin
        int lm;
        int tl;
        int ft;
        int gt;
        int dt;
        int mk;
        shadow_cfg.listen_mode   = 1'b0;
        shadow_cfg.trigger_level = RST_TRIGGER_LEVEL;
        shadow_cfg.first_timeout = RST_FIRST_TIMEOUT;
        shadow_cfg.gap_timeout   = RST_GAP_TIMEOUT;
        shadow_cfg.dead_ticks    = RST_DEAD_TICKS;
        shadow_cfg.max_knocks    = RST_MAX_KNOCKS;
        send_idle_pct = 29;
        recv_idle_pct = 54;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Plain recording with one tick of dead time and three knocks at most: a tick while idle,
        // a knock exactly at the trigger level, the run of knocks that fills the sequence, a gap
        // timeout with nothing heard, and a start that abandons a sequence in progress.
        load_settings(0, 512, 2, 2, 1, 3);
        queue_beat(CMD_TICK, 1023);
        queue_beat(CMD_START, 1023);
        queue_beat(CMD_TICK, 512);
        queue_beat(CMD_TICK, 1023);
        queue_beat(CMD_TICK, 1023);
        queue_beat(CMD_TICK, 0);
        queue_beat(CMD_TICK, 1023);
        queue_beat(CMD_START, 0);
        queue_beat(CMD_TICK, 0);
        queue_beat(CMD_TICK, 0);
        queue_beat(CMD_TICK, 0);
        queue_beat(CMD_START, 511);
        queue_beat(CMD_TICK, 1023);
        queue_beat(CMD_START, 0);
        queue_beat(CMD_TICK, 700);
        settle();

        // Listening with no knocks allowed: the first knock finishes the sequence empty, and a
        // quiet listen runs into the first-knock timeout.
        load_settings(1, 1, 1, 0, 0, 0);
        queue_beat(CMD_START, 0);
        queue_beat(CMD_TICK, 1);
        queue_beat(CMD_START, 1023);
        queue_beat(CMD_TICK, 0);
        queue_beat(CMD_TICK, 0);
        settle();

        // No knocks allowed without listening: the start itself finishes the sequence.
        load_settings(0, 0, 0, 0, 0, 0);
        queue_beat(CMD_START, 1023);
        settle();

        // A first-knock timeout of zero ends on the first tick, before its sample is looked at.
        load_settings(1, 0, 0, 0, 0, 255);
        queue_beat(CMD_START, 0);
        queue_beat(CMD_TICK, 1023);
        settle();

        // Listening with no dead time: the first knock is stamped zero and the next tick may
        // already carry the final knock.
        load_settings(1, 300, 5, 3, 0, 2);
        queue_beat(CMD_START, 0);
        queue_beat(CMD_TICK, 299);
        queue_beat(CMD_TICK, 300);
        queue_beat(CMD_TICK, 1023);
        settle();

        // Random phases: both sides idling in turn, then neither.
        for (int p = 0; p < 9; p++) begin
            send_idle_pct = (p < 3) ? 29 : (p < 6) ? 54 : 0;
            recv_idle_pct = (p < 3) ? 54 : (p < 6) ? 29 : 0;
            lm = $urandom_range(1);
            tl = $urandom_range(1023);
            ft = $urandom_range(40);
            gt = $urandom_range(30);
            dt = $urandom_range(12);
            mk = $urandom_range(10);
            case (p)
                0: begin
                    // Every sample is a knock, and the sequence never fills.
                    lm = 0;
                    tl = 0;
                    ft = 65535;
                    gt = 2;
                    dt = 0;
                    mk = 255;
                end
                1: begin
                    lm = 1;
                    tl = 1023;
                    ft = 65535;
                    gt = 65535;
                    dt = 255;
                    mk = 255;
                end
                2: begin
                    lm = 1;
                    ft = 0;
                    mk = 0;
                end
                4: begin
                    lm = 0;
                    mk = $urandom_range(2);
                end
                6: begin
                    // Dense results for the long receiver hold-off below.
                    tl = 0;
                    ft = $urandom_range(10, 1);
                    gt = $urandom_range(10, 1);
                    dt = 0;
                    mk = $urandom_range(4, 1);
                end
                default: begin
                end
            endcase
            load_settings(lm, tl, ft, gt, dt, mk);
            if (p == 6) holdoff_requests++;
            queue_random_phase(tl, 185);
            settle();
        end

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ksr_pkg.sv
hdl/ksr_ctrl.sv
hdl/ksr_outq.sv
hdl/knock_sequence_recorder.sv
tb/knock_sequence_recorder_tb.sv
